/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define CDQ_ASSERT_IMPL(label, trig, cons, msg) \
   `CDQ_ASSERT(label, (trig) |-> (cons), msg)

// Check that a trigger implies a consequence in the next cycle.
`define CDQ_ASSERT_NEXT(label, trig, cons, msg) \
   `CDQ_ASSERT(label, (trig) |=> (cons), msg)

`endif

/* rtl/cdq_pkg.sv */
// Package for the circular deque: codes, state and control types, sizes.
`timescale 1ns / 1ps
package cdq_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 5;
   localparam int REQ_TDATA_W   = 32;
   localparam int RSP_TDATA_W   = 40;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic commit;
      logic capture_read;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pop_ok;
   } stat_type;

endpackage

/* rtl/cdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/cdq_datapath.sv */
// Deque datapath: indices, entry count, ring store and result register.
`timescale 1ns / 1ps
module cdq_datapath #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdq_pkg::cmd_type                    cmd,
   output cdq_pkg::stat_type                   stat,
   input  cdq_pkg::action_type                 req_action,
   input  logic signed [cdq_pkg::VALUE_W-1:0]  req_push_value,
   output logic signed [cdq_pkg::VALUE_W-1:0]  rsp_pop_value,
   output cdq_pkg::status_type                 rsp_status,
   output logic [cdq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   action_type               action_ff, action_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [IDX_W-1:0]         rear_ff, rear_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               status_ff, status_in;
   logic signed [VALUE_W-1:0] popval_ff, popval_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   status_type               out_status_ff, out_status_in;
   logic [OCC_W-1:0]         out_occ_ff, out_occ_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]       rd_data;
   logic                     is_empty;
   logic                     is_full;
   logic                     is_pop;

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);
   assign is_pop   = action_ff[1];
   assign rd_addr  = (action_ff == ACT_POP_FRONT) ? front_ff : rear_ff;
   assign stat.pop_ok = is_pop && !is_empty;

   always_comb begin
      action_in     = action_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      popval_in     = popval_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      out_occ_in    = out_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;

      if (cmd.load_req) begin
         action_in = req_action;
         value_in  = req_push_value;
      end

      if (cmd.commit) begin
         popval_in = '0;
         status_in = ST_OK;
         if (!is_pop) begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (is_empty) begin
                  front_in = '0;
                  rear_in  = '0;
                  wr_addr  = '0;
               end else if (action_ff == ACT_PUSH_FRONT) begin
                  front_in = step_down(front_ff);
                  wr_addr  = step_down(front_ff);
               end else begin
                  rear_in = step_up(rear_ff);
                  wr_addr = step_up(rear_ff);
               end
            end
         end else if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            count_in = count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               // last entry leaves: both ends return to the origin
               front_in = '0;
               rear_in  = '0;
            end else if (action_ff == ACT_POP_FRONT) begin
               front_in = step_up(front_ff);
            end else begin
               rear_in = step_down(rear_ff);
            end
         end
      end

      if (cmd.capture_read) begin
         popval_in = rd_data;
      end

      if (cmd.load_out) begin
         out_value_in  = popval_ff;
         out_status_in = status_ff;
         out_occ_in    = OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      popval_ff     <= popval_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      out_occ_ff    <= out_occ_in;
   end

   cdq_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(value_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_pop_value = out_value_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_occupancy = out_occ_ff;
endmodule

/* rtl/cdq_ctrl.sv */
// Deque controller: request sequencing and result handshake.
`timescale 1ns / 1ps
module cdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cdq_pkg::stat_type stat,
   output cdq_pkg::cmd_type  cmd
);
   import cdq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // the result slot opens when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.pop_ok ? S_READ : S_DONE;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
         end
         S_READ: begin
            cmd.capture_read = 1'b1;
         end
         S_DONE: begin
            cmd.load_out = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* rtl/circular_deque_core.sv */
// Top level of the circular double-ended queue.
`timescale 1ns / 1ps
// Fixed-depth double-ended queue held in a ring of DEPTH 32-bit words. Each request
// pushes at the front or rear, or pops from the front or rear, and yields one
// result: the popped value (zero otherwise), a status (ok, full, empty) and the
// occupancy after the action. A refused push or pop leaves the contents unchanged.
// The controller handles one request at a time, going from idle through execute to
// done; a successful pop also passes a read state, as the ring store has a registered
// read port. The result goes valid once the done state loads the output register.
// The next request is taken while the previous result still waits in the output
// register. A result that is held back stalls the following request only in its
// done state, until the output register is free. No clearing pass runs after reset.
module circular_deque_core #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cdq_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [31:0] push_value
   input  logic [cdq_pkg::ACTION_W-1:0]     req_tuser,  // [1:0] action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cdq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] pop_value, [36:32] occupancy
   output logic [cdq_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);
   import cdq_pkg::*;

   cmd_type                   cmd;
   stat_type                  stat;
   logic signed [VALUE_W-1:0] pop_value;
   status_type                status;
   logic [OCC_W-1:0]          occupancy;

   cdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   cdq_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (action_type'(req_tuser)),
      .req_push_value(req_tdata[VALUE_W-1:0]),
      .rsp_pop_value (pop_value),
      .rsp_status    (status),
      .rsp_occupancy (occupancy)
   );

   assign rsp_tdata = {(RSP_TDATA_W - VALUE_W - OCC_W)'(0), occupancy, pop_value};
   assign rsp_tuser = status;
endmodule

/* rtl/cdq_checker.sv */
// Port-level checker for the circular deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdq_checker #(
   parameter int DEPTH = cdq_pkg::DEFAULT_DEPTH
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [cdq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic [cdq_pkg::ACTION_W-1:0]     req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [cdq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [cdq_pkg::STATUS_W-1:0]     rsp_tuser
);
   import cdq_pkg::*;

   logic [OCC_W-1:0] occ;
   logic             req_fire;

   assign occ      = rsp_tdata[VALUE_W +: OCC_W];
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata)
                     && (req_tuser == req_tuser);

   `CDQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `CDQ_ASSERT_IMPL(a_refused_zero, rsp_tvalid && rsp_tuser != ST_OK,
      rsp_tdata[VALUE_W-1:0] == '0, "refused request returned a nonzero value")
   `CDQ_ASSERT_IMPL(a_empty_occ, rsp_tvalid && rsp_tuser == ST_EMPTY,
      occ == '0, "empty status with nonzero occupancy")
   `CDQ_ASSERT_IMPL(a_full_occ, rsp_tvalid && rsp_tuser == ST_FULL,
      occ == OCC_W'(DEPTH), "full status with occupancy below depth")
   `CDQ_ASSERT_NEXT(a_one_at_a_time, req_fire, !req_tready,
      "request taken before the previous one finished")
endmodule

bind circular_deque_core cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
